/* hw/rtl/itc_pkg.sv */
package itc_pkg;

    // Register indexes on the configuration port
    localparam logic [0:0] REG_ADVANCE_RATIO = 1'd0;
    localparam logic [0:0] REG_DWELL_TICKS   = 1'd1;

    // Register reset values (advance 0.19067 in Q0.16, dwell in ticks)
    localparam logic [15:0] ADVANCE_RATIO_RST = 16'd12496;
    localparam logic [15:0] DWELL_TICKS_RST   = 16'd600;

    // One tick handed from the input stage to the timer
    typedef struct packed {
        logic fire;     // a tick transaction is processed this cycle
        logic edge_in;  // that tick carries a sensor edge
    } t_tick_ctl;

    // Timer state shown on the result channel
    typedef struct packed {
        logic        coil_line;
        logic        tach_line;
        logic        counting;
        logic [15:0] last_period;
    } t_tick_res;

endpackage

/* hw/rtl/itc_timer.sv */
module itc_timer import itc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_tick_ctl   i_ctl,
    input  logic [15:0] i_advance_ratio,
    input  logic [15:0] i_dwell_ticks,
    output t_tick_res   o_res
);

    logic [15:0] r_tick_count, n_tick_count;
    logic        r_run_flag, n_run_flag;
    logic [15:0] r_fire_point, n_fire_point;
    logic [15:0] r_release_point, n_release_point;
    logic        r_coil_level, n_coil_level;
    logic        r_tach_level, n_tach_level;
    logic [15:0] r_period_hold, n_period_hold;

    logic [31:0] prod;
    logic [15:0] fire_new;
    logic [15:0] count_next;
    logic        hit_a;
    logic        hit_b;

    // Firing point from the captured period: period * ratio, Q0.16 truncated
    assign prod       = {16'd0, r_tick_count} * {16'd0, i_advance_ratio};
    assign fire_new   = prod[31:16];
    assign count_next = r_tick_count + 16'd1;
    assign hit_a      = (count_next == r_fire_point);
    assign hit_b      = (count_next == r_release_point);

    // Next state for one tick
    always_comb begin
        n_tick_count    = r_tick_count;
        n_run_flag      = r_run_flag;
        n_fire_point    = r_fire_point;
        n_release_point = r_release_point;
        n_coil_level    = r_coil_level;
        n_tach_level    = r_tach_level;
        n_period_hold   = r_period_hold;
        if (i_ctl.fire) begin
            if (i_ctl.edge_in) begin
                // capture period, restart counter, new compares
                n_period_hold   = r_tick_count;
                n_tick_count    = '0;
                n_run_flag      = 1'b1;
                n_fire_point    = fire_new;
                n_release_point = {1'b0, r_tick_count[15:1]} - fire_new;
            end else if (r_run_flag) begin
                n_tick_count = count_next;
                if (count_next == '0) begin
                    // wrap: release coil and stop
                    n_coil_level = 1'b1;
                    n_run_flag   = 1'b0;
                end else begin
                    // compare A acts first, then B against the old release point
                    if (hit_a) begin
                        n_tach_level    = ~r_tach_level;
                        n_coil_level    = 1'b0;
                        n_release_point = r_fire_point + i_dwell_ticks;
                    end
                    if (hit_b) begin
                        n_coil_level = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count    <= '0;
            r_run_flag      <= 1'b0;
            r_fire_point    <= '0;
            r_release_point <= '0;
            r_coil_level    <= 1'b1;
            r_tach_level    <= 1'b0;
            r_period_hold   <= '0;
        end else begin
            r_tick_count    <= n_tick_count;
            r_run_flag      <= n_run_flag;
            r_fire_point    <= n_fire_point;
            r_release_point <= n_release_point;
            r_coil_level    <= n_coil_level;
            r_tach_level    <= n_tach_level;
            r_period_hold   <= n_period_hold;
        end
    end

    assign o_res.coil_line   = r_coil_level;
    assign o_res.tach_line   = r_tach_level;
    assign o_res.counting    = r_run_flag;
    assign o_res.last_period = r_period_hold;

endmodule

/* hw/rtl/ignition_timing_controller_unit.sv */
// Channel   Direction  Handshake          Payload
// tick in   input      i_valid / o_stall  i_sensor_edge
// result    output     o_valid / i_stall  o_coil_line, o_tach_line, o_counting, o_last_period
// config    input      i_cfg_we           i_cfg_addr, i_cfg_data
//
// One tick per clock unless the result channel stalls: input register, then timer state
// (the result register). The 16x16 firing-point multiply sets the longest path.
// Synchronous active-low reset: coil high, tach low, counter stopped, registers to defaults.
// A stall on a full result register freezes the timer and a loaded input stage (o_stall).
module ignition_timing_controller_unit import itc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_sensor_edge,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_coil_line,
    output logic        o_tach_line,
    output logic        o_counting,
    output logic [15:0] o_last_period,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);

    logic        r_in_vld;
    logic        r_in_edge;
    logic        r_out_vld;
    logic [15:0] r_advance_ratio;
    logic [15:0] r_dwell_ticks;
    logic        out_hold;
    t_tick_ctl   tick_ctl;
    t_tick_res   tick_res;

    // Result register full and not taken: pipeline holds
    assign out_hold = r_out_vld & i_stall;
    assign o_stall  = r_in_vld & out_hold;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_advance_ratio <= ADVANCE_RATIO_RST;
            r_dwell_ticks   <= DWELL_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ADVANCE_RATIO: r_advance_ratio <= i_cfg_data;
                REG_DWELL_TICKS:   r_dwell_ticks   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_edge <= i_sensor_edge;
        end
    end

    // Result valid flag; the timer state itself is the result payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!out_hold) begin
            r_out_vld <= r_in_vld;
        end
    end

    assign tick_ctl.fire    = r_in_vld & ~out_hold;
    assign tick_ctl.edge_in = r_in_edge;

    itc_timer u_timer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (tick_ctl),
        .i_advance_ratio (r_advance_ratio),
        .i_dwell_ticks   (r_dwell_ticks),
        .o_res           (tick_res)
    );

    assign o_valid       = r_out_vld;
    assign o_coil_line   = tick_res.coil_line;
    assign o_tach_line   = tick_res.tach_line;
    assign o_counting    = tick_res.counting;
    assign o_last_period = tick_res.last_period;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import itc_pkg::*;

    localparam int unsigned QUIET_LIMIT  = 3000;  // cycles without any transaction
    localparam int unsigned SETTLE_TICKS = 4;     // pipeline depth plus margin
    localparam int unsigned IDLE_PCT     = 21;
    localparam int unsigned HOLD_AFTER   = 500;   // results seen before the long hold-off
    localparam int unsigned HOLD_CYCLES  = 90;
    localparam int unsigned MAX_REPORTS  = 50;

    // Timing predictor plus queue of coil/tach levels still owed by the block
    class CoilTimingBook;
        logic [15:0] ratio;
        logic [15:0] dwell;
        logic [15:0] count;
        logic [15:0] fire_at;
        logic [15:0] release_at;
        logic [15:0] period;
        logic        running;
        logic        coil;
        logic        tach;
        t_tick_res   due_levels[$];
        int unsigned failures;

        function new();
            ratio      = ADVANCE_RATIO_RST;
            dwell      = DWELL_TICKS_RST;
            count      = '0;
            fire_at    = '0;
            release_at = '0;
            period     = '0;
            running    = 1'b0;
            coil       = 1'b1;
            tach       = 1'b0;
            failures   = 0;
        endfunction

        function int unsigned pending();
            return due_levels.size();
        endfunction

        function void set_register(logic [0:0] idx, logic [15:0] value);
            case (idx)
                REG_ADVANCE_RATIO: ratio = value;
                REG_DWELL_TICKS:   dwell = value;
                default: ;
            endcase
        endfunction

        function void report(string what);
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("%0t: %s", $time, what);
            end
            if (failures == MAX_REPORTS) begin
                $display("%0t: further mismatches not shown", $time);
            end
        endfunction

        // Advance the timer model by one accepted tick transaction
        function void take_tick(logic edge_bit);
            logic [31:0] product;
            logic [15:0] next_count;
            logic        hit_fire;
            logic        hit_release;
            if (edge_bit) begin
                // capture period, restart counter, place both compare points
                product    = {16'd0, count} * {16'd0, ratio};
                period     = count;
                count      = '0;
                running    = 1'b1;
                fire_at    = product[31:16];
                release_at = (period >> 1) - product[31:16];
            end else if (running) begin
                next_count = count + 16'd1;
                count      = next_count;
                if (next_count == 16'd0) begin
                    // wrap: coil released, counter stops, no compares
                    coil    = 1'b1;
                    running = 1'b0;
                end else begin
                    hit_fire    = (next_count == fire_at);
                    hit_release = (next_count == release_at);
                    if (hit_fire) begin
                        tach       = ~tach;
                        coil       = 1'b0;
                        release_at = fire_at + dwell;
                    end
                    // release acts after fire, so a double hit leaves the coil high
                    if (hit_release) begin
                        coil = 1'b1;
                    end
                end
            end
            due_levels.push_back({coil, tach, running, period});
        endfunction

        function void match_levels(t_tick_res got);
            t_tick_res want;
            if (due_levels.size() == 0) begin
                report($sformatf("unexpected result coil=%0b tach=%0b counting=%0b period=%0d",
                                 got.coil_line, got.tach_line, got.counting, got.last_period));
                return;
            end
            want = due_levels.pop_front();
            if (got !== want) begin
                report($sformatf({"mismatch: expected coil=%0b tach=%0b counting=%0b ",
                                  "period=%0d, got coil=%0b tach=%0b counting=%0b period=%0d"},
                                 want.coil_line, want.tach_line, want.counting,
                                 want.last_period, got.coil_line, got.tach_line,
                                 got.counting, got.last_period));
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        i_sensor_edge = 1'b0;
    logic        i_stall       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [0:0]  i_cfg_addr    = REG_ADVANCE_RATIO;
    logic [15:0] i_cfg_data    = '0;
    logic        o_stall;
    logic        o_valid;
    logic        o_coil_line;
    logic        o_tach_line;
    logic        o_counting;
    logic [15:0] o_last_period;

    CoilTimingBook book;
    bit            steady = 1'b0;  // no idling on either side while set
    int unsigned   results_seen = 0;
    int unsigned   quiet_cycles = 0;

    ignition_timing_controller_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sensor_edge (i_sensor_edge),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_coil_line   (o_coil_line),
        .o_tach_line   (o_tach_line),
        .o_counting    (o_counting),
        .o_last_period (o_last_period),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Offer one tick transaction, with random idle cycles ahead of it
    task automatic send_tick(input logic edge_bit);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sensor_edge <= edge_bit;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        book.take_tick(edge_bit);
    endtask

    // Stop offering and let every owed result drain out
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // Both registers written back to back while the block is idle
    task automatic set_timing(input logic [15:0] ratio, input logic [15:0] dwell);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= REG_ADVANCE_RATIO;
        i_cfg_data <= ratio;
        @(posedge i_clk);
        book.set_register(REG_ADVANCE_RATIO, ratio);
        i_cfg_addr <= REG_DWELL_TICKS;
        i_cfg_data <= dwell;
        @(posedge i_clk);
        book.set_register(REG_DWELL_TICKS, dwell);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly edge-then-count sequences, some raw edge noise
    task automatic run_phase(input int unsigned items, input bit pause_midway);
        int unsigned sent;
        int unsigned gap;
        bit          paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < items) begin
            if (pause_midway && !paused && sent >= items / 2) begin
                paused = 1'b1;
                wait_drained();
            end
            if ($urandom_range(99) < 80) begin
                send_tick(1'b1);
                sent++;
                gap = ($urandom_range(19) == 0) ? $urandom_range(200, 41)
                                                : $urandom_range(40, 1);
                repeat (gap) begin
                    send_tick(1'b0);
                    sent++;
                end
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    send_tick($urandom_range(1) == 1);
                    sent++;
                end
            end
        end
    endtask

    // Result side: check, then pick next stall; one long hold-off to back up the block
    initial begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                book.match_levels({o_coil_line, o_tach_line, o_counting, o_last_period});
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            i_stall <= (hold_left > 0) || (!steady && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog on cycles with no transaction on any port
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        book = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: stopped ticks, edge capturing zero, double compare hits, release only
        set_timing(16'h4000, 16'd2);
        repeat (2) send_tick(1'b0);
        send_tick(1'b1);
        repeat (8) send_tick(1'b0);
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);

        // Random sequences over several register settings
        set_timing(16'($urandom_range(65535)), 16'($urandom_range(20)));
        run_phase(225, 1'b0);
        set_timing(16'h0000, 16'h0000);
        run_phase(225, 1'b0);
        set_timing(16'hFFFF, 16'hFFFF);
        run_phase(225, 1'b0);
        set_timing(ADVANCE_RATIO_RST, DWELL_TICKS_RST);
        steady = 1'b1;
        run_phase(225, 1'b0);
        steady = 1'b0;
        set_timing(16'($urandom_range(65535)), 16'($urandom_range(65535)));
        run_phase(225, 1'b1);
        set_timing(16'($urandom_range(65535)), 16'($urandom_range(40)));
        run_phase(225, 1'b0);

        wait_drained();
        if (book.failures == 0 && book.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
